// File: sv/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and codes of the healthy backend selector: item and result
// payloads, table entry layout, register indexes and controller states.
// ----------------------------------------------------------------------------
package hbs_pkg;

	localparam int SLOT_W   = 4;
	localparam int NUM_SLOTS = 1 << SLOT_W;
	localparam int CONN_W   = 16;
	localparam int CNT8_W   = 8;
	localparam int MASK_W   = 16;
	localparam int ROT_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Item kinds
	localparam logic [1:0] MODE_SELECT  = 2'd0;
	localparam logic [1:0] MODE_HEALTH  = 2'd1;
	localparam logic [1:0] MODE_SETCONN = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	// Selection algorithms
	localparam logic ALGO_RR = 1'b0;
	localparam logic ALGO_LC = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALGO = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HTHR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UTHR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd3;

	localparam logic [CNT8_W-1:0] CNT8_MAX = 8'hFF;

	typedef struct packed {
		logic              algo;
		logic [CNT8_W-1:0] hthr;
		logic [CNT8_W-1:0] uthr;
		logic [MASK_W-1:0] mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{algo: ALGO_RR, hthr: 8'd2, uthr: 8'd3, mask: '0};

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot;
		logic              passed;
		logic [CONN_W-1:0] connections;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] chosen_slot;
		logic              is_healthy;
		logic              state_changed;
	} res_t;

	localparam res_t RES_NONE = '{found: 1'b0, chosen_slot: '0, is_healthy: 1'b0,
		state_changed: 1'b0};

	typedef struct packed {
		logic              healthy;
		logic [CNT8_W-1:0] fails;
		logic [CNT8_W-1:0] checks;
		logic [CONN_W-1:0] active;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{healthy: 1'b1, fails: '0, checks: '0, active: '0};

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
	} tbl_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT,
		ST_DIV,
		ST_PICK,
		ST_LC,
		ST_RD,
		ST_WR,
		ST_DONE
	} state_t;

endpackage

// File: sv/hbs_ifs.sv
// ----------------------------------------------------------------------------
// hbs channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface hbs_item_if;
	import hbs_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [SLOT_W-1:0] slot;
	logic              passed;
	logic [CONN_W-1:0] connections;
	modport source (output valid, mode, slot, passed, connections, input ready);
	modport sink   (input valid, mode, slot, passed, connections, output ready);
endinterface

interface hbs_result_if;
	import hbs_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [SLOT_W-1:0] chosen_slot;
	logic              is_healthy;
	logic              state_changed;
	modport source (output valid, found, chosen_slot, is_healthy, state_changed, input ready);
	modport sink   (input valid, found, chosen_slot, is_healthy, state_changed, output ready);
endinterface

interface hbs_cfg_if;
	import hbs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/healthy_backend_selector_core.sv
// ----------------------------------------------------------------------------
// healthy_backend_selector_core
// Backend table with health tracking and round-robin or least-connections
// selection over present, healthy slots.
// ----------------------------------------------------------------------------
// One item is in work at a time; D = min(NUM_BACKENDS, 16) table slots are
// scanned through the table memory, one entry per cycle. A health result or
// a connection load for an in-range slot is a read-modify-write of one entry.
// A least-connections select is one scan of the table. A round-robin select
// runs a counting scan of the table, a modulo of the rotation counter by the
// usable-slot count in a bit-serial divider, and a walk over the usable
// slots; with no usable slot it ends after the scan. Mode 3 items are taken
// and give no result. The result waits in an output register, so a new item
// is taken while the previous result is not yet taken. The register port is
// always ready; write it only while the block is idle.
module healthy_backend_selector_core #(
	parameter int NUM_BACKENDS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	hbs_item_if.sink     item,
	hbs_result_if.source result,
	hbs_cfg_if.sink      cfg
);
	import hbs_pkg::*;

	localparam int DEPTH = (NUM_BACKENDS < NUM_SLOTS) ? NUM_BACKENDS : NUM_SLOTS;
	localparam int CW    = $clog2(DEPTH + 1);

	cfg_t             cfg_q;
	item_t            item_in;
	res_t             ctrl_res;
	res_t             res_q;
	logic             res_vld_q;
	logic             ctrl_res_valid;
	logic             ctrl_res_ready;
	tbl_req_t         tbl_req;
	entry_t           rd_data;
	logic             div_start;
	logic [ROT_W-1:0] div_dividend;
	logic [CW-1:0]    div_divisor;
	logic             div_done;
	logic [CW-1:0]    div_rem;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ALGO: cfg_q.algo <= cfg.data[0];
				REG_HTHR: cfg_q.hthr <= cfg.data[CNT8_W-1:0];
				REG_UTHR: cfg_q.uthr <= cfg.data[CNT8_W-1:0];
				REG_MASK: cfg_q.mask <= cfg.data[MASK_W-1:0];
				default:  ;
			endcase
		end
	end

	assign item_in = '{mode: item.mode, slot: item.slot, passed: item.passed,
		connections: item.connections};

	hbs_table #(.DEPTH(DEPTH)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (rd_data)
	);

	hbs_mod #(.CW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	hbs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.item         (item_in),
		.res_valid    (ctrl_res_valid),
		.res_ready    (ctrl_res_ready),
		.res          (ctrl_res),
		.tbl_req      (tbl_req),
		.rd_data      (rd_data),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_rem      (div_rem)
	);

	// Output register: load when empty or being drained
	assign ctrl_res_ready = !res_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ctrl_res_valid && ctrl_res_ready) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res_valid && ctrl_res_ready) begin
			res_q <= ctrl_res;
		end
	end

	assign result.valid         = res_vld_q;
	assign result.found         = res_q.found;
	assign result.chosen_slot   = res_q.chosen_slot;
	assign result.is_healthy    = res_q.is_healthy;
	assign result.state_changed = res_q.state_changed;

endmodule

// File: sv/hbs_table.sv
// ----------------------------------------------------------------------------
// hbs_table
// Backend table: one synchronous memory of entries with a registered read
// port and a write port. Entries never written since reset read as healthy
// with all counts zero.
// ----------------------------------------------------------------------------
module hbs_table #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hbs_pkg::tbl_req_t req,
	output hbs_pkg::entry_t   rd_data
);
	import hbs_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t           mem_q [DEPTH];
	entry_t           rd_s1;
	logic             rd_vld_s1;
	logic [DEPTH-1:0] vld_q;
	logic [IW-1:0]    ra;
	logic [IW-1:0]    wa;

	assign ra = req.rd_addr[IW-1:0];
	assign wa = req.wr_addr[IW-1:0];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wa] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_s1 <= mem_q[ra];
		end
	end

	// Track written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[wa] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[ra];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_s1 : ENTRY_RESET;

endmodule

// File: sv/hbs_mod.sv
// ----------------------------------------------------------------------------
// hbs_mod
// Iterative modulo unit: restoring division of a 32-bit dividend by a
// narrow divisor, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module hbs_mod #(
	parameter int CW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [hbs_pkg::ROT_W-1:0] dividend,
	input  logic [CW-1:0]             divisor,
	output logic                      done,
	output logic [CW-1:0]             rem
);
	import hbs_pkg::*;

	localparam int STEP_W = $clog2(ROT_W);

	logic [ROT_W-1:0]  dvd_q;
	logic [CW-1:0]     dsr_q;
	logic [CW-1:0]     rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[ROT_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ROT_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, dsr_q}) ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	// Step count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(ROT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ROT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: sv/hbs_ctrl.sv
// ----------------------------------------------------------------------------
// hbs_ctrl
// Item sequencer: scans the table for a select, runs read-modify-write for
// health results and connection loads, and hands on one result for each item but mode 3.
// ----------------------------------------------------------------------------
module hbs_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hbs_pkg::cfg_t             cfg,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  hbs_pkg::item_t            item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output hbs_pkg::res_t             res,
	output hbs_pkg::tbl_req_t         tbl_req,
	input  hbs_pkg::entry_t           rd_data,
	output logic                      div_start,
	output logic [hbs_pkg::ROT_W-1:0] div_dividend,
	output logic [$clog2(DEPTH+1)-1:0] div_divisor,
	input  logic                      div_done,
	input  logic [$clog2(DEPTH+1)-1:0] div_rem
);
	import hbs_pkg::*;

	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CTR_W = IW + 1;

	state_t           state_q;
	state_t           state_d;
	item_t            it_q;
	res_t             pend_q;
	res_t             upd_res;
	entry_t           upd_entry;
	logic [CTR_W-1:0] ctr_q;
	logic             vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [CW-1:0]    cnt_q;
	logic [DEPTH-1:0] usable_q;
	logic [IW-1:0]    pk_q;
	logic [CW-1:0]    seen_q;
	logic             have_q;
	logic [IW-1:0]    best_idx_q;
	logic [CONN_W-1:0] best_act_q;
	logic [ROT_W-1:0] rot_q;
	logic             use_s1;
	logic             scan_last;
	logic             issue;
	logic             slot_bad;
	logic             pick_hit;

	assign use_s1    = vld_s1 && cfg.mask[SLOT_W'(idx_s1)] && rd_data.healthy;
	assign scan_last = (ctr_q == CTR_W'(DEPTH)) && !vld_s1;
	assign issue     = (ctr_q != CTR_W'(DEPTH));
	assign slot_bad  = ({1'b0, item.slot} >= (SLOT_W + 1)'(DEPTH));
	assign pick_hit  = usable_q[pk_q] && (seen_q == div_rem);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.mode == MODE_SELECT) begin
						state_d = (cfg.algo == ALGO_LC) ? ST_LC : ST_CNT;
					end else if (item.mode == MODE_NONE) begin
						state_d = ST_IDLE;
					end else begin
						state_d = slot_bad ? ST_DONE : ST_RD;
					end
				end
			end
			ST_CNT: begin
				if (scan_last) begin
					state_d = (cnt_q == '0) ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV:  if (div_done) state_d = ST_PICK;
			ST_PICK: if (pick_hit) state_d = ST_DONE;
			ST_LC:   if (scan_last) state_d = ST_DONE;
			ST_RD:   state_d = ST_WR;
			ST_WR:   state_d = ST_DONE;
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		item_ready      = 1'b0;
		res_valid       = 1'b0;
		div_start       = 1'b0;
		tbl_req.rd_en   = 1'b0;
		tbl_req.rd_addr = SLOT_W'(ctr_q[IW-1:0]);
		tbl_req.wr_en   = 1'b0;
		tbl_req.wr_addr = it_q.slot;
		tbl_req.wr_data = upd_entry;
		unique case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_CNT: begin
				tbl_req.rd_en = issue;
				div_start     = scan_last && (cnt_q != '0);
			end
			ST_LC:   tbl_req.rd_en = issue;
			ST_RD: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_addr = it_q.slot;
			end
			ST_WR:   tbl_req.wr_en = 1'b1;
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Update one entry for a health result or a connection load
	always_comb begin
		upd_entry = rd_data;
		upd_res   = '{found: 1'b1, chosen_slot: it_q.slot, is_healthy: rd_data.healthy,
			state_changed: 1'b0};
		if (it_q.mode == MODE_SETCONN) begin
			upd_entry.active = it_q.connections;
		end else begin
			if (rd_data.checks != CNT8_MAX) begin
				upd_entry.checks = rd_data.checks + 8'd1;
			end
			if (it_q.passed) begin
				upd_entry.fails = '0;
				if (!rd_data.healthy && (upd_entry.checks >= cfg.hthr)) begin
					upd_entry.healthy = 1'b1;
				end
			end else begin
				if (rd_data.fails != CNT8_MAX) begin
					upd_entry.fails = rd_data.fails + 8'd1;
				end
				if (upd_entry.fails >= cfg.uthr) begin
					upd_entry.healthy = 1'b0;
				end
			end
			upd_res.is_healthy    = upd_entry.healthy;
			upd_res.state_changed = upd_entry.healthy != rd_data.healthy;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q   <= '0;
			vld_s1  <= 1'b0;
			rot_q   <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ((state_q == ST_CNT) || (state_q == ST_LC)) && issue;
			if (state_q == ST_IDLE) begin
				ctr_q <= '0;
			end else if (((state_q == ST_CNT) || (state_q == ST_LC)) && issue) begin
				ctr_q <= ctr_q + CTR_W'(1);
			end
			if ((state_q == ST_PICK) && pick_hit) begin
				rot_q <= rot_q + ROT_W'(1);
			end
		end
	end

	// Datapath of the scans and the pending result
	always_ff @(posedge clk) begin
		idx_s1 <= ctr_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					it_q   <= item;
					cnt_q  <= '0;
					have_q <= 1'b0;
					pend_q <= '{found: 1'b1, chosen_slot: item.slot, is_healthy: 1'b0,
						state_changed: 1'b0};
				end
			end
			ST_CNT: begin
				if (vld_s1) begin
					usable_q[idx_s1] <= use_s1;
					cnt_q            <= cnt_q + CW'(use_s1);
				end
				if (scan_last) begin
					pk_q   <= '0;
					seen_q <= '0;
					pend_q <= RES_NONE;
				end
			end
			ST_PICK: begin
				pk_q <= pk_q + IW'(1);
				if (usable_q[pk_q]) begin
					if (seen_q == div_rem) begin
						pend_q <= '{found: 1'b1, chosen_slot: SLOT_W'(pk_q), is_healthy: 1'b1,
							state_changed: 1'b0};
					end else begin
						seen_q <= seen_q + CW'(1);
					end
				end
			end
			ST_LC: begin
				if (use_s1 && (!have_q || (rd_data.active < best_act_q))) begin
					have_q     <= 1'b1;
					best_act_q <= rd_data.active;
					best_idx_q <= idx_s1;
				end
				if (scan_last) begin
					pend_q <= have_q ? '{found: 1'b1, chosen_slot: SLOT_W'(best_idx_q),
						is_healthy: 1'b1, state_changed: 1'b0} : RES_NONE;
				end
			end
			ST_WR:   pend_q <= upd_res;
			default: ;
		endcase
	end

	assign res          = pend_q;
	assign div_dividend = rot_q;
	assign div_divisor  = cnt_q;

endmodule

// File: sv/hbs_checker.sv
// ----------------------------------------------------------------------------
// hbs_checker
// Port-level checks of the healthy backend selector, bound to the top level.
// ----------------------------------------------------------------------------
module hbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic [1:0]                item_mode,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      res_found,
	input logic [hbs_pkg::SLOT_W-1:0] res_slot,
	input logic                      res_healthy,
	input logic                      res_changed
);
	import hbs_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_slot) && $stable(res_found)
			&& $stable(res_healthy) && $stable(res_changed))
		else $error("result changed while stalled");

	// An empty select reports nothing else
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> !res_healthy && !res_changed && (res_slot == '0))
		else $error("empty select carries data");

	// Only a health result flips a flag, and it always reports found
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_changed |-> res_found)
		else $error("state change without found");

	// One item in work: a transfer that yields a result closes the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_mode != MODE_NONE) |=> !item_ready)
		else $error("input open while an item is in work");

endmodule

bind healthy_backend_selector_core hbs_checker u_hbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_mode   (item.mode),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.found),
	.res_slot    (result.chosen_slot),
	.res_healthy (result.is_healthy),
	.res_changed (result.state_changed)
);
